// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted min-priority queue.
// Holds the capacity, counter widths, operation and status codes, and the
// structs that run between the control logic and the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OUT_W    = 40;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // Per-cell position flags derived from the entry count.
  typedef struct packed {
    logic occ;
    logic tail;
  } pos_t;

  // Data handed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic                    ge;
    logic signed [VAL_W-1:0] entry;
  } link_t;

endpackage

`default_nettype wire

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted queue.
// Holds one entry, compares it with the incoming value, and on an insert
// shifts right or captures the value; on a remove it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                                 clk_i,
  input  wire spq_pkg::cmd_t                  cmd_i,
  input  wire spq_pkg::pos_t                  pos_i,
  input  wire spq_pkg::link_t                 left_i,
  input  wire logic signed [spq_pkg::VAL_W-1:0] right_entry_i,
  output spq_pkg::link_t                      link_o
);

  logic signed [spq_pkg::VAL_W-1:0] entry_q, entry_d;
  logic                             ge;

  assign ge = pos_i.occ && (entry_q >= cmd_i.value);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_i.ge) begin
        entry_d = left_i.entry;
      end else if (ge || pos_i.tail) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.ge    = ge;
  assign link_o.entry = entry_q;

endmodule

`default_nettype wire

// File: hdl/sorted_min_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_top: sorted min-priority queue of signed values.
// Up to spq_pkg::CAPACITY values sit in a chain of cells in ascending order.
// Every cell compares its entry with an incoming value at once, so an insert
// or a remove updates every cell and one beat is accepted per clock when not
// stalled; its result beat appears on the output register the next cycle. The
// output register is the only stage between the two sides, so the input stalls
// only while a result beat is held by the downstream side. Each input beat
// gives exactly one result beat. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_min_priority_queue_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [spq_pkg::VAL_W-1:0]         s_axis_tdata,  // [31:0] value
  input  wire                              s_axis_tuser,  // [0] func
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [spq_pkg::OUT_W-1:0]        m_axis_tdata   // [31:0] removed_value,
                                                          // [33:32] status,
                                                          // [38:34] occupancy,
                                                          // [39] zero
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic                             accept;
  logic                             full, empty;
  logic                             is_ins, is_rem;
  logic [spq_pkg::CNT_W-1:0]        count_q, count_d;
  spq_pkg::cmd_t                    cmd;
  spq_pkg::pos_t                    pos   [N];
  spq_pkg::link_t                   links [N];
  spq_pkg::link_t                   lefts [N];
  logic signed [spq_pkg::VAL_W-1:0] rights[N];

  logic                             out_valid_q;
  logic signed [spq_pkg::VAL_W-1:0] removed_q, removed_d;
  spq_pkg::status_e                 status_q, status_d;
  logic [spq_pkg::OCC_W-1:0]        occ_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == spq_pkg::CAP_CNT);
  assign empty         = (count_q == '0);
  assign is_ins        = (spq_pkg::func_e'(s_axis_tuser) == spq_pkg::FUNC_INSERT);
  assign is_rem        = (spq_pkg::func_e'(s_axis_tuser) == spq_pkg::FUNC_REMOVE);

  assign cmd.ins   = accept && is_ins && !full;
  assign cmd.rem   = accept && is_rem && !empty;
  assign cmd.value = s_axis_tdata;

  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    status_d  = spq_pkg::ST_OK;
    if (cmd.ins) begin
      count_d = count_q + 1'b1;
    end else if (cmd.rem) begin
      count_d   = count_q - 1'b1;
      removed_d = links[0].entry;
    end
    if (is_ins && full) begin
      status_d = spq_pkg::ST_OVERFLOW;
    end else if (is_rem && empty) begin
      status_d = spq_pkg::ST_UNDERFLOW;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign pos[i].occ  = (count_q > spq_pkg::CNT_W'(i));
    assign pos[i].tail = (count_q == spq_pkg::CNT_W'(i));
    if (i == 0) begin : g_first
      assign lefts[i] = '0;
    end else begin : g_rest
      assign lefts[i] = links[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rights[i] = links[i].entry;
    end else begin : g_mid
      assign rights[i] = links[i+1].entry;
    end
    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .pos_i        (pos[i]),
      .left_i       (lefts[i]),
      .right_entry_i(rights[i]),
      .link_o       (links[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      occ_q     <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, occ_q, status_q, removed_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CAP_CNT)
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_rem_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> (removed_q == $past(links[0].entry)) && (status_q == spq_pkg::ST_OK))
    else $error("remove did not return the head entry");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && full) |=> (count_q == $past(count_q)) &&
                                   (status_q == spq_pkg::ST_OVERFLOW))
    else $error("overflow changed the queue");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule

`default_nettype wire

// File: verif/sorted_min_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_top_tb: self-checking bench for the sorted queue.
// A shadow copy of the queue, kept as a sorted list, predicts every result
// beat: the removed minimum, the status and the occupancy. Directed beats
// cover the value extremes, equal values, remove on empty and insert on full.
// Random beats then run in insert-heavy, remove-heavy and balanced bursts. Both stream
// sides idle at random. The bench also holds the result side off for a long
// stretch and waits for every result to drain, once mid-run and again at the end.
// ----------------------------------------------------------------------------

module sorted_min_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int unsigned RAND_BEATS  = 1800;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    status_e                 status;
    logic [OCC_W-1:0]        occupancy;
  } queue_result_t;

  class queue_scoreboard;
    logic signed [VAL_W-1:0] held[$];
    queue_result_t           expected[$];
    int unsigned             errors;

    function void record_op(func_e op, logic signed [VAL_W-1:0] v);
      queue_result_t r;
      int unsigned   pos;
      r.removed_value = '0;
      r.status        = ST_OK;
      if (op == FUNC_INSERT) begin
        if (held.size() >= CAPACITY) begin
          r.status = ST_OVERFLOW;
        end else begin
          pos = held.size();
          for (int unsigned i = 0; i < held.size(); i++) begin
            if (held[i] >= v) begin
              pos = i;
              break;
            end
          end
          held.insert(pos, v);
        end
      end else if (held.size() == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.removed_value = held.pop_front();
      end
      r.occupancy = OCC_W'(held.size());
      expected.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      queue_result_t exp_r;
      logic signed [VAL_W-1:0] got_value;
      logic [STAT_W-1:0]       got_status;
      logic [OCC_W-1:0]        got_occ;
      got_value  = beat[VAL_W-1:0];
      got_status = beat[VAL_W+STAT_W-1:VAL_W];
      got_occ    = beat[VAL_W+STAT_W+OCC_W-1:VAL_W+STAT_W];
      if (expected.size() == 0) begin
        $error("result beat with no expectation pending: tdata=%h", beat);
        errors++;
        return;
      end
      exp_r = expected.pop_front();
      if (got_value !== exp_r.removed_value) begin
        $error("removed_value: expected %0d, got %0d", exp_r.removed_value, got_value);
        errors++;
      end
      if (got_status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got_status);
        errors++;
      end
      if (got_occ !== exp_r.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp_r.occupancy, got_occ);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [VAL_W-1:0]     s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;

  queue_scoreboard sb;
  logic            tx_idle_en;
  logic            rx_idle_en;
  logic            hold_request;
  int unsigned     cycle_count;

  sorted_min_priority_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_min_priority_queue_top_tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4: begin
        return $urandom;
      end
      5, 6, 7: begin
        return VAL_W'($signed($urandom_range(0, 8)) - 4);
      end
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fff_ffff;
          1:       return 32'sh8000_0000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) return 32'sh7fff_fff8 + $urandom_range(0, 7);
        return 32'sh8000_0000 + $urandom_range(0, 7);
      end
    endcase
  endfunction

  task automatic send_op(input func_e op, input logic signed [VAL_W-1:0] v);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.record_op(op, v);
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    logic        hold_seen;
    stall_left    = 0;
    hold_left     = 0;
    hold_seen     = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_request && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_en) begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned insert_pct;
    int unsigned burst_left;
    func_e       op;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_INSERT;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    hold_request  = 1'b0;
    insert_pct    = 50;
    burst_left    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats: empty remove, extremes and equal values, fill, overflow.
    send_op(FUNC_REMOVE, 32'sd0);
    send_op(FUNC_INSERT, 32'sh7fff_ffff);
    send_op(FUNC_INSERT, 32'sh8000_0000);
    send_op(FUNC_INSERT, 32'sd0);
    send_op(FUNC_INSERT, -32'sd1);
    send_op(FUNC_INSERT, 32'sd1);
    send_op(FUNC_INSERT, 32'sd5);
    send_op(FUNC_INSERT, 32'sd5);
    send_op(FUNC_INSERT, -32'sd5);
    repeat (CAPACITY - 8) send_op(FUNC_INSERT, pick_value());
    send_op(FUNC_INSERT, 32'sh8000_0000);
    send_op(FUNC_INSERT, 32'sh7fff_ffff);
    repeat (4) send_op(FUNC_REMOVE, $urandom);

    for (int unsigned n = 0; n < RAND_BEATS; n++) begin
      if (n == 600) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (n == 900) begin
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_request = 1'b1;
      end
      if (n == 1200) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.outstanding() != 0);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      burst_left--;
      op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
      send_op(op, pick_value());
    end

    s_axis_tvalid <= 1'b0;
    rx_idle_en = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("sorted_min_priority_queue_top_tb: done, clean");
    end else begin
      $display("sorted_min_priority_queue_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_min_priority_queue_top.sv
verif/sorted_min_priority_queue_top_tb.sv
